// File: src/pal_pkg.sv
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

  localparam int VALUE_W         = 32;
  localparam int POS_W           = 5;
  localparam int CAP_W           = 5;
  localparam int COUNT_OUT_W     = 5;
  localparam int REQ_W           = 2;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAX_ENTRIES_HI  = 64;
  // wide enough for any count up to the largest list size
  localparam int PAL_CNT_W       = $clog2(MAX_ENTRIES_HI + 1);

  localparam int RESULT_LIMIT    = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = REQ_W;
  localparam int OUT_TDATA_W     = 40;
  localparam int OUT_TUSER_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_DUMP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    PAL_IDLE,
    PAL_DUMP
  } pal_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                   op;
    logic [PAL_CNT_W-1:0]       pos_idx;
    logic [PAL_CNT_W-1:0]       count;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/pal_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbours.
`default_nettype none

module pal_cell #(
  parameter int IDX = 0
) (
  input  wire logic                               clk,
  input  wire pal_pkg::cell_cmd_t                 cmd,
  input  wire logic signed [pal_pkg::VALUE_W-1:0] left_val,
  input  wire logic signed [pal_pkg::VALUE_W-1:0] right_val,
  input  wire logic signed [pal_pkg::VALUE_W-1:0] head_val,
  output logic signed [pal_pkg::VALUE_W-1:0]      val
);
  import pal_pkg::*;

  localparam logic [PAL_CNT_W-1:0] ID     = PAL_CNT_W'(IDX);
  localparam logic [PAL_CNT_W-1:0] ID_INC = PAL_CNT_W'(IDX + 1);

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_APPEND: begin
        if (ID == cmd.count) val_nxt = cmd.value;
      end
      CELL_INSERT: begin
        if (ID == cmd.pos_idx) begin
          val_nxt = cmd.value;
        end else if (ID > cmd.pos_idx && ID <= cmd.count) begin
          val_nxt = left_val;
        end
      end
      CELL_REMOVE: begin
        if (ID >= cmd.pos_idx && ID_INC < cmd.count) val_nxt = right_val;
      end
      CELL_ROTATE: begin
        // advance towards the head; the tail entry wraps from the head
        if (ID_INC < cmd.count) begin
          val_nxt = right_val;
        end else if (ID_INC == cmd.count) begin
          val_nxt = head_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

// File: src/positional_array_list.sv
// Top level of the positional array list: request decode, dump sequencer and cell chain.
//
// Stores a packed list of signed 32-bit entries in a chain of cells, one entry per cell.
// Requests arrive on the in_ stream: tuser carries the kind (append, insert, remove,
// dump); tdata carries the one-based position and the value. Results leave on the out_
// stream, each with the status, the entry (dumps only), the count and the empty and full
// flags; tlast marks the final result of a request.
// Append, insert and remove move every affected cell in the same edge, and an edit's
// single result is presented on the cycle after the transfer.
// A dump rotates the chain by one cell per cycle unless stalled, reading each entry at
// the head; an empty list gives a single empty result. Only the first 16 entries are
// emitted; the rotation still completes so the order is restored when it ends.
// A new request is taken only with no dump in progress and the output register free or
// being drained in the same cycle. A stalled receiver holds the output register and
// freezes the dump rotation, while entries remain to be emitted, until the result is taken.
// Reset (rst_n low, synchronous) empties the list, drops any pending result and sets the
// capacity limit to 16. cfg_wr_en writes the capacity limit; write it only while idle.
// A limit of 0 acts as 1 and one above MAX_ENTRIES acts as MAX_ENTRIES.
`default_nettype none

module positional_array_list #(
  parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [pal_pkg::CAP_W-1:0]            cfg_wr_data,  // capacity_limit
  // request stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [pal_pkg::IN_TDATA_W-1:0]       in_tdata,     // position[4:0],
                                                                  // item_value[36:5], zero pad
  input  wire logic [pal_pkg::IN_TUSER_W-1:0]       in_tuser,     // req_type[1:0]
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [pal_pkg::OUT_TDATA_W-1:0]           out_tdata,    // entry_value[31:0],
                                                                  // entry_count[36:32],
                                                                  // is_empty[37], is_full[38]
  output logic [pal_pkg::OUT_TUSER_W-1:0]           out_tuser,    // status[0], entry_valid[1]
  output logic                                      out_tlast     // last_of_run
);
  import pal_pkg::*;

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // Request fields
  req_t                       req;
  logic [POS_W-1:0]           position;
  logic signed [VALUE_W-1:0]  item_value;

  assign req        = req_t'(in_tuser[REQ_W-1:0]);
  assign position   = in_tdata[POS_W-1:0];
  assign item_value = in_tdata[POS_W +: VALUE_W];

  // State
  pal_state_t                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              dump_idx_r, dump_idx_nxt;
  logic [CAP_W-1:0]           cap_r;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                       out_evalid_r, out_evalid_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [COUNT_OUT_W-1:0]     out_count_r, out_count_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic                       out_full_r, out_full_nxt;

  // Handshake and decode
  logic                       slot_free;
  logic                       in_fire;
  logic [CMPW-1:0]            eff_cap;
  logic [CMPW-1:0]            count_ext;
  logic                       list_full;
  logic                       at_max;
  logic                       pos_ok;
  logic                       dump_emit;
  logic                       dump_advance;
  logic                       dump_last;
  logic                       dump_done;
  logic                       load_out;

  cell_cmd_t                  cmd;
  logic signed [VALUE_W-1:0]  cell_val [MAX_ENTRIES];

  assign slot_free = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign count_ext = CMPW'(count_r);

  // Clamp the capacity register into 1..MAX_ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = CMPW'(cap_r);
    end
  end

  assign list_full = count_ext >= eff_cap;
  assign at_max    = count_r == CW'(MAX_ENTRIES);
  assign pos_ok    = (position != '0) && (CMPW'(position) <= count_ext);

  // Dump sequencing: silent rotations past the result limit need no output slot
  assign dump_emit    = CMPW'(dump_idx_r) < CMPW'(RESULT_LIMIT);
  assign dump_advance = (state_r == PAL_DUMP) && (slot_free || !dump_emit);
  assign dump_done    = dump_idx_r == (count_r - CW'(1));
  assign dump_last    = (count_ext > CMPW'(RESULT_LIMIT)) ?
                        (CMPW'(dump_idx_r) == CMPW'(RESULT_LIMIT - 1)) : dump_done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PAL_IDLE: begin
        if (in_fire && req == REQ_DUMP && count_r != '0) state_nxt = PAL_DUMP;
      end
      PAL_DUMP: begin
        if (dump_advance && dump_done) state_nxt = PAL_IDLE;
      end
      default: state_nxt = PAL_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready, cell command, count and result load
  always_comb begin
    in_tready      = 1'b0;
    cmd.op         = CELL_NONE;
    cmd.pos_idx    = PAL_CNT_W'(position - POS_W'(1));
    cmd.count      = PAL_CNT_W'(count_r);
    cmd.value      = item_value;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    load_out       = 1'b0;
    out_status_nxt = 1'b0;
    out_value_nxt  = '0;
    out_evalid_nxt = 1'b0;
    out_last_nxt   = 1'b1;
    case (state_r)
      PAL_IDLE: begin
        in_tready    = slot_free;
        dump_idx_nxt = '0;
        if (in_fire) begin
          case (req)
            REQ_APPEND: begin
              load_out = 1'b1;
              if (list_full || at_max) begin
                out_status_nxt = 1'b1;
              end else begin
                cmd.op    = CELL_APPEND;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_INSERT: begin
              load_out = 1'b1;
              if (list_full || at_max || !pos_ok) begin
                out_status_nxt = 1'b1;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_REMOVE: begin
              load_out = 1'b1;
              if (!pos_ok) begin
                out_status_nxt = 1'b1;
              end else begin
                cmd.op    = CELL_REMOVE;
                count_nxt = count_r - CW'(1);
              end
            end
            REQ_DUMP: begin
              // an empty list answers at once with a single empty result
              load_out = (count_r == '0);
            end
            default: load_out = 1'b0;
          endcase
        end
      end
      PAL_DUMP: begin
        if (dump_advance) begin
          cmd.op         = CELL_ROTATE;
          dump_idx_nxt   = dump_idx_r + CW'(1);
          load_out       = dump_emit;
          out_value_nxt  = cell_val[0];
          out_evalid_nxt = 1'b1;
          out_last_nxt   = dump_last;
        end
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Flags reflect the count after the request
  assign out_count_nxt = COUNT_OUT_W'(count_nxt);
  assign out_empty_nxt = (count_nxt == '0);
  assign out_full_nxt  = CMPW'(count_nxt) >= eff_cap;
  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PAL_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  // Result payload: hold until the next load
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_evalid_r <= out_evalid_nxt;
      out_last_r   <= out_last_nxt;
      out_count_r  <= out_count_nxt;
      out_empty_r  <= out_empty_nxt;
      out_full_r   <= out_full_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_evalid_r, out_status_r};
  assign out_tdata  = {{(OUT_TDATA_W - VALUE_W - COUNT_OUT_W - 2){1'b0}},
                       out_full_r, out_empty_r, out_count_r, out_value_r};

  // Cell chain: cell 0 is the head of the list
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    pal_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

endmodule

`default_nettype wire

// File: tb/positional_array_list_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional array list: directed and random requests.

// One result transfer as seen on the out_ stream, unpacked into its fields.
typedef struct packed {
  logic                status;
  logic signed [31:0]  value;
  logic                valid;
  logic                last;
  logic [4:0]          count;
  logic                empty;
  logic                full;
} list_result_t;

class list_scoreboard;
  logic signed [31:0]  entries [16];
  logic [4:0]          count;
  logic [4:0]          capacity;
  list_result_t        expected_q [$];
  int                  errors;
  int                  checked;
  int                  rejected;
  int                  kinds [4];

  function new();
    for (int i = 0; i < 16; i++) entries[i] = '0;
    count    = '0;
    capacity = pal_pkg::CAP_RESET;
    errors   = 0;
    checked  = 0;
    rejected = 0;
    for (int i = 0; i < 4; i++) kinds[i] = 0;
  endfunction

  // Capacity as the block applies it: 0 acts as 1, anything above 16 as 16.
  function int eff_capacity();
    if (capacity == 0) return 1;
    if (capacity > 16) return 16;
    return int'(capacity);
  endfunction

  function void push_result(logic st, logic signed [31:0] val, logic vld, logic lst);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.valid  = vld;
    r.last   = lst;
    r.count  = count;
    r.empty  = (count == 0);
    r.full   = (int'(count) >= eff_capacity());
    if (st) rejected++;
    expected_q.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue what it yields.
  function void note_request(pal_pkg::req_t kind, logic [4:0] pos, logic signed [31:0] val);
    bit is_full;
    int p;
    int n;
    is_full = (int'(count) >= eff_capacity());
    p = int'(pos);
    n = int'(count);
    kinds[int'(kind)]++;
    case (kind)
      pal_pkg::REQ_DUMP: begin
        if (n == 0) push_result(1'b0, '0, 1'b0, 1'b1);
        else for (int k = 0; k < n; k++) push_result(1'b0, entries[k], 1'b1, k == n - 1);
      end
      pal_pkg::REQ_APPEND: begin
        if (is_full || n >= 16) push_result(1'b1, '0, 1'b0, 1'b1);
        else begin
          entries[n] = val;
          count++;
          push_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
      pal_pkg::REQ_INSERT: begin
        if (is_full || p < 1 || p > n || n >= 16) push_result(1'b1, '0, 1'b0, 1'b1);
        else begin
          for (int i = n; i > p - 1; i--) entries[i] = entries[i - 1];
          entries[p - 1] = val;
          count++;
          push_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        if (n == 0 || p < 1 || p > n) push_result(1'b1, '0, 1'b0, 1'b1);
        else begin
          for (int i = p - 1; i + 1 < n; i++) entries[i] = entries[i + 1];
          count--;
          push_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function void check_result(logic [39:0] tdata, logic [1:0] tuser, logic tlast);
    list_result_t got;
    list_result_t want;
    got.value  = tdata[31:0];
    got.count  = tdata[36:32];
    got.empty  = tdata[37];
    got.full   = tdata[38];
    got.status = tuser[0];
    got.valid  = tuser[1];
    got.last   = tlast;
    checked++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with nothing expected: st=%0b val=%0d vld=%0b last=%0b cnt=%0d",
                 $time, got.status, got.value, got.valid, got.last, got.count);
      return;
    end
    want = expected_q.pop_front();
    if (got != want) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: mismatch expected st=%0b val=%0d vld=%0b last=%0b cnt=%0d e=%0b f=%0b",
                 $time, want.status, want.value, want.valid, want.last, want.count,
                 want.empty, want.full);
        $display("%0t:          actual   st=%0b val=%0d vld=%0b last=%0b cnt=%0d e=%0b f=%0b",
                 $time, got.status, got.value, got.valid, got.last, got.count,
                 got.empty, got.full);
      end
    end
  endfunction
endclass

module positional_array_list_test;
  import pal_pkg::*;

  // Worst case is far below this: ~250 requests, up to 16 results each, a receiver
  // that idles about two thirds of the time, plus the drains between blocks.
  localparam int LIMIT_CYCLES = 400000;
  // Cycles to let pass after the last result before touching the register.
  localparam int SETTLE       = 20;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]        cfg_wr_data = '0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata    = '0;  // position[4:0], item_value[36:5], zero pad
  logic [IN_TUSER_W-1:0]   in_tuser    = '0;  // req_type[1:0]
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;         // entry_value[31:0], entry_count[36:32],
                                              // is_empty[37], is_full[38]
  logic [OUT_TUSER_W-1:0]  out_tuser;         // status[0], entry_valid[1]
  logic                    out_tlast;         // last_of_run

  list_scoreboard sb;

  // Chance in a hundred that either side idles on a given cycle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  // Capacity plan for the nine random blocks, and whether each block favours growth.
  int cap_plan  [9] = '{16, 31, 5, 0, 16, 20, 1, 9, 16};
  bit grow_plan [9] = '{1, 0, 0, 1, 1, 0, 0, 1, 0};

  positional_array_list u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: check every result transfer at the edge it happens, then pick the
  // next cycle's ready at random according to the current idling pattern.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // on return so a back-to-back request needs no drop in between.
  task automatic transfer_request(req_t kind, logic [4:0] pos, logic signed [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, val, pos};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, pos, val);
  endtask

  // Hold off the sender until every queued result has been seen, then settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the capacity register; only call with the block idle.
  task automatic write_capacity(logic [4:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.capacity = cap;
  endtask

  // Random requests: mostly positions inside the list so edits land, with a share
  // of boundary and out-of-range positions; grow blocks lean towards appends.
  task automatic random_block(int n, bit grow);
    int r;
    req_t kind;
    logic [4:0] pos;
    logic signed [31:0] val;
    repeat (n) begin
      r = $urandom_range(99);
      if (grow) kind = (r < 50) ? REQ_APPEND : (r < 70) ? REQ_INSERT :
                       (r < 85) ? REQ_REMOVE : REQ_DUMP;
      else      kind = (r < 28) ? REQ_APPEND : (r < 52) ? REQ_INSERT :
                       (r < 80) ? REQ_REMOVE : REQ_DUMP;
      r = $urandom_range(99);
      if (sb.count != 0 && r < 75) pos = 5'($urandom_range(int'(sb.count), 1));
      else if (r < 85)             pos = sb.count + 5'd1;
      else                         pos = 5'($urandom_range(31, 0));
      case ($urandom_range(15))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = '0;
        default: val = $urandom;
      endcase
      transfer_request(kind, pos, val);
    end
  endtask

  initial begin
    sb = new();
    // Hold reset, then release it once for the whole run.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_capacity(5'd16);

    // Directed: empty-list cases first.
    transfer_request(REQ_DUMP,   5'd0,  32'sh0000_0000);
    transfer_request(REQ_REMOVE, 5'd1,  32'sh1234_5678);
    transfer_request(REQ_INSERT, 5'd1,  32'sh1234_5678);
    // Fill with the value extremes.
    transfer_request(REQ_APPEND, 5'd0,  32'sh7FFF_FFFF);
    transfer_request(REQ_APPEND, 5'd31, 32'sh8000_0000);
    transfer_request(REQ_APPEND, 5'd0,  32'sh0000_0000);
    transfer_request(REQ_APPEND, 5'd31, -32'sd1);
    // Insert at the head and in the middle, then the rejected positions.
    transfer_request(REQ_INSERT, 5'd1,  32'shA5A5_A5A5);
    transfer_request(REQ_INSERT, 5'd3,  32'sh5A5A_5A5A);
    transfer_request(REQ_INSERT, 5'd0,  32'sh0BAD_0BAD);
    transfer_request(REQ_INSERT, 5'd7,  32'sh0BAD_0BAD);
    transfer_request(REQ_INSERT, 5'd31, 32'sh0BAD_0BAD);
    transfer_request(REQ_REMOVE, 5'd0,  32'sh0000_0000);
    transfer_request(REQ_REMOVE, 5'd7,  32'sh0000_0000);
    transfer_request(REQ_REMOVE, 5'd31, 32'sh0000_0000);
    transfer_request(REQ_DUMP,   5'd0,  32'sh0000_0000);
    // Remove the head and the tail.
    transfer_request(REQ_REMOVE, 5'd1,  32'sh0000_0000);
    transfer_request(REQ_REMOVE, 5'd5,  32'sh0000_0000);
    transfer_request(REQ_DUMP,   5'd0,  32'sh0000_0000);

    // Lower the capacity below the count: the list reads as full but keeps its entries.
    wait_idle();
    write_capacity(5'd3);
    transfer_request(REQ_APPEND, 5'd0,  32'sh0F0F_0F0F);
    transfer_request(REQ_INSERT, 5'd1,  32'sh0F0F_0F0F);
    transfer_request(REQ_DUMP,   5'd0,  32'sh0000_0000);
    transfer_request(REQ_REMOVE, 5'd2,  32'sh0000_0000);
    transfer_request(REQ_APPEND, 5'd0,  32'sh0F0F_0F0F);
    transfer_request(REQ_DUMP,   5'd0,  32'sh0000_0000);
    wait_idle();

    // Random part: three idling patterns, three blocks each, with a drain and a
    // capacity change between blocks.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= (ph == 0) ? 17 : (ph == 1) ? 66 : 0;
      recv_idle_pct <= (ph == 0) ? 66 : (ph == 1) ? 17 : 0;
      for (int b = 0; b < 3; b++) begin
        write_capacity(5'(cap_plan[ph * 3 + b]));
        random_block(25, grow_plan[ph * 3 + b]);
        wait_idle();
      end
    end

    // Anything still queued never arrived.
    sb.errors += sb.expected_q.size();
    $display("Covered %0d requests (%0d append, %0d insert, %0d remove, %0d dump), %0d rejected.",
             sb.kinds[0] + sb.kinds[1] + sb.kinds[2] + sb.kinds[3],
             sb.kinds[0], sb.kinds[1], sb.kinds[2], sb.kinds[3], sb.rejected);
    $display("Checked %0d results over capacities 0 to 31 and three idling patterns: %0d errors.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: positional_array_list.f
src/pal_pkg.sv
src/pal_cell.sv
src/positional_array_list.sv
tb/positional_array_list_test.sv
